### sv/wtt_pkg.sv
// Shared types and constants for the watch tick timekeeper.
package wtt_pkg;

  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned SECS_PER_DAY  = SECS_PER_HOUR * HOURS_PER_DAY;

  localparam int unsigned HOUR_W = 5;
  localparam int unsigned SIH_W  = 12;
  localparam int unsigned TOD_W  = 17;

  localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(HOURS_PER_DAY - 1);
  localparam logic [SIH_W-1:0]  SIH_LAST  = SIH_W'(SECS_PER_HOUR - 1);

  localparam logic signed [15:0] COUNTDOWN_RESET = 16'sd100;

  localparam logic [4:0] CHIME_FIRST_HOUR_RESET = 5'd8;
  localparam logic [4:0] WAKE_HOUR_RESET        = 5'd8;

  localparam logic CFG_CHIME_FIRST_HOUR = 1'b0;
  localparam logic CFG_WAKE_HOUR        = 1'b1;

  typedef enum logic [2:0] {
    REQ_TICK_100MS  = 3'd0,
    REQ_TICK_1S     = 3'd1,
    REQ_VIBRATE     = 3'd2,
    REQ_LOAD_TIMER  = 3'd3,
    REQ_STOPWATCH   = 3'd4,
    REQ_RELOAD_CD   = 3'd5,
    REQ_RESYNC      = 3'd6,
    REQ_SET_TIME    = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    TRK_NONE    = 2'd0,
    TRK_SLEEP   = 2'd1,
    TRK_GESTURE = 2'd2
  } trk_t;

  typedef struct packed {
    logic              done;
    logic [HOUR_W-1:0] hour;
    logic [SIH_W-1:0]  sec_in_hour;
  } daytime_t;

  typedef struct packed {
    logic              vibro_on;
    logic [31:0]       seconds;
    logic              hour_event;
    logic [HOUR_W-1:0] hour;
    logic [2:0]        chime_pulses;
    logic              steps_clear;
    trk_t              tracker_switch;
    logic              timer_expired;
    logic              alarm_check;
    logic [31:0]       stopwatch_tenths;
    logic [31:0]       up_seconds;
    logic [31:0]       down_seconds;
  } result_t;

endpackage

### sv/wtt_daytime.sv
// Converts a loaded seconds value into hour of day and seconds within the hour.
module wtt_daytime import wtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        take,
  input  logic [31:0] value,
  output daytime_t    dt
);

  typedef logic [TOD_W-1:0] tod_tab_t [256];

  localparam int unsigned STEP_BYTE3 = (2 ** 24) % SECS_PER_DAY;
  localparam int unsigned STEP_BYTE2 = (2 ** 16) % SECS_PER_DAY;

  function automatic tod_tab_t gen_residue_tab(input logic [TOD_W-1:0] step);
    tod_tab_t       tab;
    logic [TOD_W:0] acc;
    acc = '0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = acc[TOD_W-1:0];
      acc = acc + (TOD_W+1)'(step);
      if (acc >= (TOD_W+1)'(SECS_PER_DAY)) begin
        acc = acc - (TOD_W+1)'(SECS_PER_DAY);
      end
    end
    return tab;
  endfunction

  localparam tod_tab_t TOD_BYTE3 = gen_residue_tab(TOD_W'(STEP_BYTE3));
  localparam tod_tab_t TOD_BYTE2 = gen_residue_tab(TOD_W'(STEP_BYTE2));

  typedef enum logic [1:0] {
    DT_IDLE,
    DT_SPLIT,
    DT_DONE
  } dt_state_t;

  dt_state_t         state;
  logic [TOD_W-1:0]  tod;
  logic [HOUR_W-1:0] hour;
  logic [SIH_W-1:0]  sec_in_hour;

  logic [TOD_W:0]    sum;
  logic [TOD_W:0]    sum_red;
  logic [TOD_W-1:0]  tod_next;
  logic [HOUR_W-1:0] hour_next;
  logic [TOD_W-1:0]  hour_base;
  logic [SIH_W-1:0]  sec_in_hour_next;

  // The two upper bytes of the value are reduced by their own residue tables; the two lower bytes are added directly.
  always_comb begin
    sum = (TOD_W+1)'(TOD_BYTE3[value[31:24]]) + (TOD_W+1)'(TOD_BYTE2[value[23:16]])
        + (TOD_W+1)'({value[15:8], 8'h00}) + (TOD_W+1)'(value[7:0]);
    if (sum >= (TOD_W+1)'(2 * SECS_PER_DAY)) begin
      sum_red = sum - (TOD_W+1)'(2 * SECS_PER_DAY);
    end else begin
      sum_red = sum;
    end
    if (sum_red >= (TOD_W+1)'(SECS_PER_DAY)) begin
      tod_next = TOD_W'(sum_red - (TOD_W+1)'(SECS_PER_DAY));
    end else begin
      tod_next = TOD_W'(sum_red);
    end
  end

  always_comb begin
    hour_next = '0;
    hour_base = '0;
    for (int k = 1; k < HOURS_PER_DAY; k++) begin
      if (tod >= TOD_W'(k * SECS_PER_HOUR)) begin
        hour_next = HOUR_W'(k);
        hour_base = TOD_W'(k * SECS_PER_HOUR);
      end
    end
    sec_in_hour_next = SIH_W'(tod - hour_base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DT_IDLE;
    end else begin
      unique case (state)
        DT_IDLE: begin
          if (start) begin
            state <= DT_SPLIT;
          end
          tod <= tod_next;
        end
        DT_SPLIT: begin
          state       <= DT_DONE;
          hour        <= hour_next;
          sec_in_hour <= sec_in_hour_next;
        end
        DT_DONE: begin
          if (take) begin
            state <= DT_IDLE;
          end
        end
        default: begin
          state <= DT_IDLE;
        end
      endcase
    end
  end

  assign dt.done        = (state == DT_DONE);
  assign dt.hour        = hour;
  assign dt.sec_in_hour = sec_in_hour;

endmodule

### sv/wtt_core.sv
// Timekeeping state and the per-event update that forms each result.
module wtt_core import wtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        step,
  input  req_t        req,
  input  logic [31:0] arg,
  input  daytime_t    dt,
  output result_t     res
);

  localparam logic [2:0] CHIME_TAB [32] = '{
    3'd6, 3'd2, 3'd4, 3'd6, 3'd2, 3'd4, 3'd6, 3'd2,
    3'd4, 3'd6, 3'd2, 3'd4, 3'd6, 3'd2, 3'd4, 3'd6,
    3'd2, 3'd4, 3'd6, 3'd2, 3'd4, 3'd6, 3'd2, 3'd4,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  logic [4:0]        chime_first_hour;
  logic [4:0]        wake_hour;
  logic [31:0]       seconds_count;
  logic [HOUR_W-1:0] hour;
  logic [SIH_W-1:0]  sec_in_hour;
  logic signed [15:0] display_countdown;
  logic [15:0]       vibro_left;
  logic              motor_level;
  logic [31:0]       timer_left;
  logic              stopwatch_running;
  logic [31:0]       stopwatch_count;
  logic              two_second_phase;
  logic [31:0]       up_count;
  logic [31:0]       down_count;

  logic [31:0]       seconds_count_next;
  logic [HOUR_W-1:0] hour_next;
  logic [SIH_W-1:0]  sec_in_hour_next;
  logic signed [15:0] display_countdown_next;
  logic [15:0]       vibro_left_next;
  logic              motor_level_next;
  logic [31:0]       timer_left_next;
  logic              stopwatch_running_next;
  logic [31:0]       stopwatch_count_next;
  logic              two_second_phase_next;
  logic [31:0]       up_count_next;
  logic [31:0]       down_count_next;
  logic              hour_event;
  logic [2:0]        chime_pulses;
  logic              steps_clear;
  trk_t              tracker;
  logic              timer_expired;
  logic              alarm_check;

  always_comb begin
    seconds_count_next     = seconds_count;
    hour_next              = hour;
    sec_in_hour_next       = sec_in_hour;
    display_countdown_next = display_countdown;
    vibro_left_next        = vibro_left;
    motor_level_next       = motor_level;
    timer_left_next        = timer_left;
    stopwatch_running_next = stopwatch_running;
    stopwatch_count_next   = stopwatch_count;
    two_second_phase_next  = two_second_phase;
    up_count_next          = up_count;
    down_count_next        = down_count;
    hour_event             = 1'b0;
    chime_pulses           = '0;
    steps_clear            = 1'b0;
    tracker                = TRK_NONE;
    timer_expired          = 1'b0;
    alarm_check            = 1'b0;

    unique case (req)
      REQ_TICK_100MS: begin
        if (!display_countdown[15]) begin
          display_countdown_next = display_countdown - 16'sd1;
        end
        if (stopwatch_running) begin
          stopwatch_count_next = stopwatch_count + 32'd1;
        end
        if (vibro_left != '0) begin
          vibro_left_next = vibro_left - 16'd1;
          if (vibro_left == 16'd1) begin
            motor_level_next = 1'b0;
          end
        end
      end
      REQ_TICK_1S: begin
        seconds_count_next = seconds_count + 32'd1;
        // The wrap of the 32-bit counter lands on midnight.
        if (seconds_count == '1) begin
          hour_event       = 1'b1;
          hour_next        = '0;
          sec_in_hour_next = '0;
        end else if (sec_in_hour == SIH_LAST) begin
          hour_event       = 1'b1;
          sec_in_hour_next = '0;
          hour_next        = (hour == HOUR_LAST) ? '0 : hour + HOUR_W'(1);
        end else begin
          sec_in_hour_next = sec_in_hour + SIH_W'(1);
        end
        if (hour_event) begin
          if (hour_next >= chime_first_hour) begin
            chime_pulses = CHIME_TAB[hour_next];
          end
          if (hour_next == '0) begin
            steps_clear = 1'b1;
            tracker     = TRK_SLEEP;
          end
          if (hour_next == wake_hour) begin
            tracker = TRK_GESTURE;
          end
        end
        if (timer_left != '0) begin
          timer_left_next = timer_left - 32'd1;
          timer_expired   = (timer_left == 32'd1);
        end
        alarm_check           = two_second_phase;
        two_second_phase_next = !two_second_phase;
        if (display_countdown == -16'sd1) begin
          down_count_next = down_count + 32'd1;
        end else begin
          up_count_next = up_count + 32'd1;
        end
      end
      REQ_VIBRATE: begin
        motor_level_next = 1'b1;
        vibro_left_next  = arg[15:0];
      end
      REQ_LOAD_TIMER: begin
        timer_left_next = arg;
      end
      REQ_STOPWATCH: begin
        stopwatch_running_next = arg[0];
        if (arg[1]) begin
          stopwatch_count_next = '0;
        end
      end
      REQ_RELOAD_CD: begin
        display_countdown_next = signed'(arg[15:0]);
      end
      REQ_RESYNC: begin
        tracker = (hour < wake_hour) ? TRK_SLEEP : TRK_GESTURE;
      end
      REQ_SET_TIME: begin
        seconds_count_next = arg;
        hour_next          = dt.hour;
        sec_in_hour_next   = dt.sec_in_hour;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chime_first_hour  <= CHIME_FIRST_HOUR_RESET;
      wake_hour         <= WAKE_HOUR_RESET;
      seconds_count     <= '0;
      hour              <= '0;
      sec_in_hour       <= '0;
      display_countdown <= COUNTDOWN_RESET;
      vibro_left        <= '0;
      motor_level       <= 1'b0;
      timer_left        <= '0;
      stopwatch_running <= 1'b0;
      stopwatch_count   <= '0;
      two_second_phase  <= 1'b0;
      up_count          <= '0;
      down_count        <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_CHIME_FIRST_HOUR: chime_first_hour <= cfg_data;
          CFG_WAKE_HOUR:        wake_hour        <= cfg_data;
        endcase
      end
      if (step) begin
        seconds_count     <= seconds_count_next;
        hour              <= hour_next;
        sec_in_hour       <= sec_in_hour_next;
        display_countdown <= display_countdown_next;
        vibro_left        <= vibro_left_next;
        motor_level       <= motor_level_next;
        timer_left        <= timer_left_next;
        stopwatch_running <= stopwatch_running_next;
        stopwatch_count   <= stopwatch_count_next;
        two_second_phase  <= two_second_phase_next;
        up_count          <= up_count_next;
        down_count        <= down_count_next;
      end
    end
  end

  assign res.vibro_on         = motor_level_next;
  assign res.seconds          = seconds_count_next;
  assign res.hour_event       = hour_event;
  assign res.hour             = hour_next;
  assign res.chime_pulses     = chime_pulses;
  assign res.steps_clear      = steps_clear;
  assign res.tracker_switch   = tracker;
  assign res.timer_expired    = timer_expired;
  assign res.alarm_check      = alarm_check;
  assign res.stopwatch_tenths = stopwatch_count_next;
  assign res.up_seconds       = up_count_next;
  assign res.down_seconds     = down_count_next;

endmodule

### sv/watch_tick_timekeeper.sv
// Top level of the watch tick timekeeper: input stage, result register and handshakes.
//
// Each input beat is one event (req_type, arg): a 100 ms tick, a 1 s tick or a
// control event. Each input beat yields exactly one result beat, in order.
// Both channels use valid and ready; the configuration port writes
// chime_first_hour (index 0) or wake_hour (index 1) on any cycle cfg_wr_en is high.
// An accepted beat lands in an input register, and its result is registered in the
// result register once it can move. Throughput is one beat per cycle while the
// receiver is ready and no set time event is waiting. A set time event holds the input
// register while the day-time converter splits the new seconds value
// into hour and seconds within the hour over its two register stages.
// The input register also acts as a skid stage: one more beat is taken while a
// result waits. When the receiver stalls with both held, in_ready drops and the
// timekeeping counters hold.
// Reset empties both stages and returns the counters and the configuration
// registers to their reset values.
module watch_tick_timekeeper import wtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] arg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        vibro_on,
  output logic [31:0] seconds,
  output logic        hour_event,
  output logic [4:0]  hour,
  output logic [2:0]  chime_pulses,
  output logic        steps_clear,
  output logic [1:0]  tracker_switch,
  output logic        timer_expired,
  output logic        alarm_check,
  output logic [31:0] stopwatch_tenths,
  output logic [31:0] up_seconds,
  output logic [31:0] down_seconds,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  logic        in_full;
  req_t        req;
  logic [31:0] arg_q;
  result_t     res;
  result_t     res_next;
  daytime_t    dt;
  logic        advance;

  assign advance  = in_full && (!out_valid || out_ready) && (req != REQ_SET_TIME || dt.done);
  assign in_ready = !in_full || advance;

  wtt_daytime u_daytime (
    .clk   (clk),
    .rst   (rst),
    .start (in_full && req == REQ_SET_TIME),
    .take  (advance),
    .value (arg_q),
    .dt    (dt)
  );

  wtt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .req       (req),
    .arg       (arg_q),
    .dt        (dt),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      req   <= req_t'(req_type);
      arg_q <= arg;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign vibro_on         = res.vibro_on;
  assign seconds          = res.seconds;
  assign hour_event       = res.hour_event;
  assign hour             = res.hour;
  assign chime_pulses     = res.chime_pulses;
  assign steps_clear      = res.steps_clear;
  assign tracker_switch   = res.tracker_switch;
  assign timer_expired    = res.timer_expired;
  assign alarm_check      = res.alarm_check;
  assign stopwatch_tenths = res.stopwatch_tenths;
  assign up_seconds       = res.up_seconds;
  assign down_seconds     = res.down_seconds;

endmodule
